@@ design/shtq_pkg.sv @@
// Shared types, codes and defaults for the string hash table.
package shtq_pkg;

  localparam int DEF_TABLE_SLOTS = 101;
  localparam int DEF_MAX_KEY_LEN = 16;
  localparam int DEF_PROBE_LIMIT = 20;
  localparam int MAX_RESULTS     = 16;

  localparam int HASH_MUL   = 19;
  localparam int HASH_MOD   = 101;
  localparam int PROBE_LIN  = 23;
  localparam int CNT_W      = 9;

  // ceil(2^28 / 101): floor(x / 101) == (x * HASH_RCP) >> 28 for x below 2^23
  localparam int HASH_RCP    = 2657777;
  localparam int HASH_RCP_SH = 28;
  localparam int HASH_RCP_W  = 22;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_NO_ROOM  = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_byte;
    logic       key_last;
    logic [7:0] slot;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       slot_index;
    logic             slot_used;
    logic [7:0]       out_byte;
    logic             result_last;
    logic [CNT_W-1:0] entry_count;
  } rsp_item_t;

  typedef struct packed {
    logic       accept;
    logic       clr_pend;
    logic       hash_init;
    logic       hash_step;
    logic       probe_init;
    logic       probe_next;
    logic       k_clr;
    logic       k_inc;
    logic       wr_byte;
    logic       wr_final;
    logic       del;
    logic       emit;
    logic [2:0] code;
  } shtq_ctl_t;

  typedef struct packed {
    logic too_long;
    logic is_add;
    logic hash_done;
    logic full;
    logic empty;
    logic occ_pos;
    logic len_eq;
    logic byte_eq;
    logic k_last;
    logic j_last;
    logic read_ok;
    logic rd_last;
  } shtq_sts_t;

endpackage

@@ design/shtq_ctrl.sv @@
// Sequencer for key hashing, probe walk, key compare, insert copy and slot read.
module shtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  shtq_pkg::cmd_item_t cmd_item,
  input  shtq_pkg::shtq_sts_t sts,
  output shtq_pkg::shtq_ctl_t ctl,
  output logic                busy
);
  import shtq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_PINIT = 4'd3;
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_LEN   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_CK    = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;
  localparam logic [3:0] S_RSEL  = 4'd10;
  localparam logic [3:0] S_RRD   = 4'd11;
  localparam logic [3:0] S_RCK   = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        ctl.accept = start;
        if (start) begin
          if (cmd_item.command == CMD_READ) state_next = S_RSEL;
          else if (cmd_item.command != CMD_NOP && cmd_item.key_last) state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.too_long) begin
          ctl.emit = 1'b1; ctl.code = ST_TOO_LONG; ctl.clr_pend = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.hash_init = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        ctl.hash_step = 1'b1;
        if (sts.hash_done) state_next = S_PINIT;
      end
      S_PINIT: begin
        ctl.probe_init = 1'b1;
        if (sts.is_add && sts.full) begin
          ctl.emit = 1'b1; ctl.code = ST_NO_ROOM; ctl.clr_pend = 1'b1;
          state_next = S_IDLE;
        end else if (!sts.is_add && sts.empty) begin
          ctl.emit = 1'b1; ctl.code = ST_NOTFOUND; ctl.clr_pend = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!sts.occ_pos) begin
          if (sts.is_add) begin
            ctl.k_clr = 1'b1;
            state_next = S_WR;
          end else begin
            ctl.emit = 1'b1; ctl.code = ST_NOTFOUND; ctl.clr_pend = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (sts.len_eq) begin
          ctl.k_clr = 1'b1;
          state_next = S_RD;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_RD: state_next = S_CK;
      S_CK: begin
        if (!sts.byte_eq) begin
          state_next = S_NEXT;
        end else if (sts.k_last) begin
          ctl.emit = 1'b1; ctl.clr_pend = 1'b1;
          if (sts.is_add) begin
            ctl.code = ST_PRESENT;
          end else begin
            ctl.code = ST_DELETED;
            ctl.del  = 1'b1;
          end
          state_next = S_IDLE;
        end else begin
          ctl.k_inc = 1'b1;
          state_next = S_RD;
        end
      end
      S_NEXT: begin
        if (sts.j_last) begin
          ctl.emit = 1'b1; ctl.clr_pend = 1'b1;
          ctl.code = sts.is_add ? ST_NO_ROOM : ST_NOTFOUND;
          state_next = S_IDLE;
        end else begin
          ctl.probe_next = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_WR: begin
        ctl.wr_byte = 1'b1;
        if (sts.k_last) begin
          ctl.wr_final = 1'b1;
          ctl.emit = 1'b1; ctl.code = ST_INSERTED; ctl.clr_pend = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.k_inc = 1'b1;
        end
      end
      S_RSEL: begin
        if (!sts.read_ok) begin
          ctl.emit = 1'b1; ctl.code = ST_READ;
          state_next = S_IDLE;
        end else begin
          ctl.k_clr = 1'b1;
          state_next = S_RRD;
        end
      end
      S_RRD: state_next = S_RCK;
      S_RCK: begin
        ctl.emit = 1'b1; ctl.code = ST_READ;
        if (sts.rd_last) begin
          state_next = S_IDLE;
        end else begin
          ctl.k_inc = 1'b1;
          state_next = S_RRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/shtq_dpath.sv @@
// Key buffer, hash remainder unit, probe stepper, slot memories and result register.
module shtq_dpath #(
  parameter int TABLE_SLOTS = shtq_pkg::DEF_TABLE_SLOTS,
  parameter int MAX_KEY_LEN = shtq_pkg::DEF_MAX_KEY_LEN,
  parameter int PROBE_LIMIT = shtq_pkg::DEF_PROBE_LIMIT
) (
  input  logic                clk,
  input  logic                rst,
  input  shtq_pkg::cmd_item_t cmd_item,
  input  shtq_pkg::shtq_ctl_t ctl,
  output shtq_pkg::shtq_sts_t sts,
  output shtq_pkg::rsp_item_t rsp_item,
  output logic                rsp_strobe
);
  import shtq_pkg::*;

  localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
  localparam int IDX_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int J_W    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int A_W    = $clog2(TABLE_SLOTS * MAX_KEY_LEN);
  localparam int SUM_W  = $clog2(128 * MAX_KEY_LEN * (MAX_KEY_LEN + 1) / 2 + 1) + 1;
  localparam int PROD_W = SUM_W + 5;
  localparam int QM_W   = PROD_W + HASH_RCP_W;
  localparam int RES_CAP = (MAX_KEY_LEN < MAX_RESULTS) ? MAX_KEY_LEN : MAX_RESULTS;

  // pending key
  logic [7:0]              pend [MAX_KEY_LEN];
  logic [LEN_W-1:0]        plen;
  logic signed [SUM_W-1:0] wsum;
  logic                    too_long;
  logic                    is_add;
  logic [7:0]              sel;

  logic [LEN_W-1:0]        plen_inc;
  logic signed [LEN_W+8:0] term;

  assign plen_inc = plen + LEN_W'(1);
  assign term     = $signed(cmd_item.key_byte) * $signed({1'b0, plen_inc});

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= '0;
      wsum     <= '0;
      too_long <= 1'b0;
      is_add   <= 1'b1;
      sel      <= '0;
    end else if (ctl.clr_pend) begin
      plen     <= '0;
      wsum     <= '0;
      too_long <= 1'b0;
    end else if (ctl.accept) begin
      if (cmd_item.command == CMD_READ) begin
        sel <= cmd_item.slot;
      end else if (cmd_item.command != CMD_NOP) begin
        is_add <= (cmd_item.command == CMD_ADD);
        if (plen >= LEN_W'(MAX_KEY_LEN)) begin
          too_long <= 1'b1;
        end else begin
          plen <= plen_inc;
          wsum <= wsum + SUM_W'(term);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && !ctl.clr_pend && cmd_item.command != CMD_READ &&
        cmd_item.command != CMD_NOP && plen < LEN_W'(MAX_KEY_LEN))
      pend[plen[IDX_W-1:0]] <= cmd_item.key_byte;
  end

  // home slot: (|sum| * 19) mod 101 by reciprocal multiply;
  // first step forms the quotient, second the remainder
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;
  logic [6:0]        rem;
  logic              hphase;
  logic [SUM_W-1:0]  mag;
  logic [QM_W-1:0]   qmul;
  logic [PROD_W-1:0] rdiff;

  assign mag   = (wsum < 0) ? SUM_W'(-wsum) : SUM_W'(wsum);
  assign qmul  = QM_W'(prod) * QM_W'(HASH_RCP);
  assign rdiff = prod - quot * PROD_W'(HASH_MOD);

  always_ff @(posedge clk) begin
    if (ctl.hash_init) begin
      prod   <= PROD_W'(mag) * PROD_W'(HASH_MUL);
      hphase <= 1'b0;
    end else if (ctl.hash_step) begin
      if (!hphase) begin
        quot <= PROD_W'(qmul >> HASH_RCP_SH);
      end else begin
        rem  <= (rdiff >= PROD_W'(HASH_MOD)) ? 7'(rdiff - PROD_W'(HASH_MOD)) : 7'(rdiff);
      end
      hphase <= 1'b1;
    end
  end

  // probe walk by first differences: step_j = 2j + 24
  logic [SLOT_W-1:0] pos, step;
  logic [J_W-1:0]    j;
  logic [SLOT_W:0]   pos_sum, step_sum;

  assign pos_sum  = {1'b0, pos} + {1'b0, step};
  assign step_sum = {1'b0, step} + (SLOT_W + 1)'(2);

  always_ff @(posedge clk) begin
    if (ctl.probe_init) begin
      pos  <= SLOT_W'(rem);
      step <= SLOT_W'(PROBE_LIN + 1);
      j    <= '0;
    end else if (ctl.probe_next) begin
      pos  <= (pos_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) ?
              SLOT_W'(pos_sum - (SLOT_W + 1)'(TABLE_SLOTS)) : SLOT_W'(pos_sum);
      step <= (step_sum >= (SLOT_W + 1)'(TABLE_SLOTS)) ?
              SLOT_W'(step_sum - (SLOT_W + 1)'(TABLE_SLOTS)) : SLOT_W'(step_sum);
      j    <= j + J_W'(1);
    end
  end

  // byte counter for compare, copy and read-out
  logic [LEN_W-1:0] k;
  always_ff @(posedge clk) begin
    if (ctl.k_clr)      k <= '0;
    else if (ctl.k_inc) k <= k + LEN_W'(1);
  end

  // read mode is held from a read item until the next add or delete byte
  logic sel_mode;
  always_ff @(posedge clk) begin
    if (rst) sel_mode <= 1'b0;
    else if (ctl.accept && cmd_item.command != CMD_NOP)
      sel_mode <= (cmd_item.command == CMD_READ);
  end

  // slot storage
  logic [7:0]             key_mem [TABLE_SLOTS * MAX_KEY_LEN];
  logic [LEN_W-1:0]       len_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] occ;
  logic [CNT_W-1:0]       count, count_next;
  logic [SLOT_W-1:0]      tgt;
  logic [A_W-1:0]         addr;
  logic [7:0]             rdata;
  logic [LEN_W-1:0]       rlen;

  assign tgt  = sel_mode ? sel[SLOT_W-1:0] : pos;
  assign addr = A_W'(tgt) * A_W'(MAX_KEY_LEN) + A_W'(k);

  always_ff @(posedge clk) begin
    if (ctl.wr_byte) key_mem[addr] <= pend[k[IDX_W-1:0]];
    rdata <= key_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_final) len_mem[tgt] <= plen;
    rlen <= len_mem[tgt];
  end

  always_comb begin
    count_next = count;
    if (ctl.wr_final) count_next = count + CNT_W'(1);
    else if (ctl.del) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      count <= '0;
    end else begin
      if (ctl.wr_final) occ[tgt] <= 1'b1;
      if (ctl.del)      occ[tgt] <= 1'b0;
      count <= count_next;
    end
  end

  // status to the sequencer
  logic [LEN_W-1:0] n_rd;
  logic             pend_eq;
  assign n_rd    = (rlen > LEN_W'(RES_CAP)) ? LEN_W'(RES_CAP) : rlen;
  assign pend_eq = (rdata == pend[k[IDX_W-1:0]]);

  always_comb begin
    sts           = '0;
    sts.too_long  = too_long;
    sts.is_add    = is_add;
    sts.hash_done = hphase;
    sts.full      = (count == CNT_W'(TABLE_SLOTS));
    sts.empty     = (count == '0);
    sts.occ_pos   = occ[pos];
    sts.len_eq    = (rlen == plen);
    sts.byte_eq   = pend_eq;
    sts.k_last    = (k == plen - LEN_W'(1));
    sts.j_last    = (j == J_W'(PROBE_LIMIT - 1));
    sts.read_ok   = ({1'b0, sel} < 9'(TABLE_SLOTS)) && occ[sel[SLOT_W-1:0]];
    sts.rd_last   = (n_rd == '0) || (k == n_rd - LEN_W'(1));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) rsp_strobe <= 1'b0;
    else     rsp_strobe <= ctl.emit;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp_item.status      <= ctl.code;
      rsp_item.entry_count <= count_next;
      case (ctl.code) inside
        ST_READ: begin
          rsp_item.slot_index  <= sel;
          rsp_item.slot_used   <= sts.read_ok;
          rsp_item.out_byte    <= (sts.read_ok && n_rd != '0) ? rdata : 8'd0;
          rsp_item.result_last <= !sts.read_ok || sts.rd_last;
        end
        ST_INSERTED, ST_PRESENT, ST_DELETED: begin
          rsp_item.slot_index  <= 8'(pos);
          rsp_item.slot_used   <= 1'b0;
          rsp_item.out_byte    <= 8'd0;
          rsp_item.result_last <= 1'b1;
        end
        default: begin
          rsp_item.slot_index  <= 8'd0;
          rsp_item.slot_used   <= 1'b0;
          rsp_item.out_byte    <= 8'd0;
          rsp_item.result_last <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ design/string_hash_table_quadratic_probe.sv @@
// Top level of the quadratic-probe hash table for byte-string keys.
//
// Key bytes arrive one item at a time under add or delete; the item with
// key_last set runs the operation and the command on that item decides it.
// Home slot is |19 * sum(signed byte * position)| mod 101; probe j visits
// (home + j*j + 23*j) mod TABLE_SLOTS for at most PROBE_LIMIT slots. A read
// item returns the stored key of one slot, one result per byte. Results are
// not back-pressured: each one sits on rsp_item for one cycle with rsp_strobe
// high and must be taken then; it appears the cycle after the emitting state.
// Sequence: a key byte without key_last and a no-op item are only accepted. A
// read selects the slot, then reads and returns each byte in turn; an unused
// slot gives a single result. An add or delete on the final byte checks the key
// length, rejecting a too-long key, forms the mod-101 remainder by reciprocal
// multiply (quotient, then remainder) and walks the probe: each occupied slot
// has its length compared and, on a match, its key bytes read and compared one
// by one (key memory has one registered read port); an insert into an empty
// slot copies the key byte by byte. busy is high while an operation runs;
// start is taken only when busy is low.
module string_hash_table_quadratic_probe #(
  parameter int TABLE_SLOTS = shtq_pkg::DEF_TABLE_SLOTS,
  parameter int MAX_KEY_LEN = shtq_pkg::DEF_MAX_KEY_LEN,
  parameter int PROBE_LIMIT = shtq_pkg::DEF_PROBE_LIMIT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  shtq_pkg::cmd_item_t cmd_item,
  output logic                rsp_strobe,
  output shtq_pkg::rsp_item_t rsp_item
);
  import shtq_pkg::*;

  shtq_ctl_t ctl;
  shtq_sts_t sts;

  // sequencer
  shtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd_item (cmd_item),
    .sts      (sts),
    .ctl      (ctl),
    .busy     (busy)
  );

  // storage and arithmetic
  shtq_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd_item   (cmd_item),
    .ctl        (ctl),
    .sts        (sts),
    .rsp_item   (rsp_item),
    .rsp_strobe (rsp_strobe)
  );

endmodule

@@ design/shtq_checker.sv @@
// Port-level checks for the hash table, bound to the top level.
module shtq_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input shtq_pkg::cmd_item_t cmd_item,
  input logic                rsp_strobe,
  input shtq_pkg::rsp_item_t rsp_item
);
  import shtq_pkg::*;

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp_item.status != ST_READ |-> rsp_item.result_last)
    else $error("add/delete result not marked last");

  a_multi_is_read: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && !rsp_item.result_last |->
      rsp_item.status == ST_READ && rsp_item.slot_used)
    else $error("multi-result item is not a used-slot read");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp_item.result_last |=> !rsp_strobe)
    else $error("result directly after the last result of an item");

  a_final_byte_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd_item.key_last &&
      (cmd_item.command == CMD_ADD || cmd_item.command == CMD_DEL) |=> busy)
    else $error("final key byte did not start an operation");

  a_nop_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd_item.command == CMD_NOP |=> !busy && !rsp_strobe)
    else $error("no-op item caused activity");

endmodule

bind string_hash_table_quadratic_probe shtq_checker u_shtq_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd_item   (cmd_item),
  .rsp_strobe (rsp_strobe),
  .rsp_item   (rsp_item)
);
